FILE: hdl/mvb_pkg.sv
// Shared constants and types of the morph vertex blend unit.
`default_nettype none
package mvb_pkg;

  localparam int CW_DEFAULT = 16;
  localparam int WF_DEFAULT = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_FRAC_CURRENT    = 3'd0,
    REG_FRAC_PREVIOUS   = 3'd1,
    REG_BLEND_WEIGHT    = 3'd2,
    REG_BLEND_ENABLE    = 3'd3,
    REG_NORMALS_PRESENT = 3'd4
  } cfg_reg_t;

endpackage
`default_nettype wire

FILE: hdl/mvb_root_lane.sv
// One normal component's bit-per-stage search for round(|v| * 2^NF / sqrt(s)).
`default_nettype none
module mvb_root_lane import mvb_pkg::*; #(
  parameter int CW = CW_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic [CW-2:0]         en,
  input  wire logic signed [4*CW+3:0] d_in,
  input  wire logic signed [4*CW+3:0] y_in,
  input  wire logic [2*CW:0]         s_in,
  input  wire logic                  neg_in,
  output logic      [CW-2:0]         m_out,
  output logic                       neg_out
);

  localparam int NF = CW - 2;
  localparam int NS = NF + 1;
  localparam int W  = 4 * CW + 4;
  localparam int SW = 2 * CW + 1;

  logic signed [W-1:0] d_r [NS];
  logic signed [W-1:0] y_r [NS];
  logic [SW-1:0]       s_r [NS];
  logic [NF:0]         m_r [NS];
  logic                neg_r [NS];

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam int B = NF - j;
    logic signed [W-1:0] d_prev, y_prev, s_ext, delta, trial;
    logic [SW-1:0]       s_prev;
    logic [NF:0]         m_prev;
    logic                neg_prev;

    if (j == 0) begin : g_first
      assign d_prev   = d_in;
      assign y_prev   = y_in;
      assign s_prev   = s_in;
      assign m_prev   = '0;
      assign neg_prev = neg_in;
    end else begin : g_next
      assign d_prev   = d_r[j-1];
      assign y_prev   = y_r[j-1];
      assign s_prev   = s_r[j-1];
      assign m_prev   = m_r[j-1];
      assign neg_prev = neg_r[j-1];
    end

    // Trial bit B: (2t-1)^2 s grows by s*(2^(B+2)(2m-1) + 2^(2B+2)).
    assign s_ext = $signed(W'(s_prev));
    assign delta = (y_prev <<< (B + 2)) + (s_ext <<< (2 * B + 2));
    assign trial = d_prev - delta;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        s_r[j]   <= s_prev;
        neg_r[j] <= neg_prev;
        if (!trial[W-1]) begin
          d_r[j] <= trial;
          y_r[j] <= y_prev + (s_ext <<< (B + 1));
          m_r[j] <= m_prev | ((NF+1)'(1) << B);
        end else begin
          d_r[j] <= d_prev;
          y_r[j] <= y_prev;
          m_r[j] <= m_prev;
        end
      end
    end
  end

  assign m_out   = m_r[NS-1];
  assign neg_out = neg_r[NS-1];

endmodule
`default_nettype wire

FILE: hdl/morph_vertex_blend_unit.sv
// Top level of the morph vertex blend unit: keyframe lerp, crossfade, renormalize.
`default_nettype none
// Takes one vertex per clock while out_ready is high and returns one result per vertex,
// in order. Each vertex lerps the current clip's keyframes by frac_current and, while
// blend_enable is set and blend_weight is below one, the previous clip's keyframes by
// frac_previous, then blends previous toward current by blend_weight. The normal is
// rescaled to unit length with round-half-up; absent or zero-length normals give
// (0,1,0). There are six arithmetic stages, CW-1 stages of the normalization search
// (one result bit per stage) and the output register. Every stage holds its own valid
// bit, so bubbles close up under a downstream stall. Write configuration only while
// the pipeline is empty; cfg_ready is always high.
module morph_vertex_blend_unit import mvb_pkg::*; #(
  parameter int COMPONENT_WIDTH  = CW_DEFAULT,
  parameter int WEIGHT_FRAC_BITS = WF_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  wire logic [WEIGHT_FRAC_BITS:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [3*COMPONENT_WIDTH-1:0]  cur_pos_from,
  input  wire logic [3*COMPONENT_WIDTH-1:0]  cur_pos_to,
  input  wire logic [3*COMPONENT_WIDTH-1:0]  prev_pos_from,
  input  wire logic [3*COMPONENT_WIDTH-1:0]  prev_pos_to,
  input  wire logic [3*COMPONENT_WIDTH-1:0]  cur_nrm_from,
  input  wire logic [3*COMPONENT_WIDTH-1:0]  cur_nrm_to,
  input  wire logic [3*COMPONENT_WIDTH-1:0]  prev_nrm_from,
  input  wire logic [3*COMPONENT_WIDTH-1:0]  prev_nrm_to,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [3*COMPONENT_WIDTH-1:0]       position_out,
  output logic [3*COMPONENT_WIDTH-1:0]       normal_out
);

  localparam int CW   = COMPONENT_WIDTH;
  localparam int WF   = WEIGHT_FRAC_BITS;
  localparam int NF   = CW - 2;
  localparam int PW   = CW + WF + 3;       // lerp product width
  localparam int W    = 4 * CW + 4;        // root search remainder width
  localparam int SW   = 2 * CW + 1;        // sum of squares width
  localparam int NROOT = NF + 1;
  localparam int ROOT0 = 6;                // first root stage index
  localparam int DEPTH = ROOT0 + NROOT + 1;
  localparam logic [WF:0]    WONE = (WF+1)'(1) << WF;
  localparam logic [PW-1:0]  HALF = PW'(1) << (WF - 1);

  // ---------------- configuration registers ----------------
  logic [WF:0] frac_current, frac_previous, blend_weight;
  logic        blend_enable, normals_present;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frac_current    <= '0;
      frac_previous   <= '0;
      blend_weight    <= WONE;
      blend_enable    <= 1'b0;
      normals_present <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAC_CURRENT:    frac_current    <= cfg_data;
        REG_FRAC_PREVIOUS:   frac_previous   <= cfg_data;
        REG_BLEND_WEIGHT:    blend_weight    <= cfg_data;
        REG_BLEND_ENABLE:    blend_enable    <= cfg_data[0];
        REG_NORMALS_PRESENT: normals_present <= cfg_data[0];
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // Clamp weights above one; the user must keep config static while items are in flight, the block does not enforce it.
  logic [WF:0] tc, tp, wb;
  logic        blending;
  assign tc = (frac_current  > WONE) ? WONE : frac_current;
  assign tp = (frac_previous > WONE) ? WONE : frac_previous;
  assign wb = (blend_weight  > WONE) ? WONE : blend_weight;
  assign blending = blend_enable && (wb < WONE);

  // ---------------- stage handshake ----------------
  // Stage i loads when it is empty or its successor moves.
  logic [DEPTH-1:0] vld;
  logic [DEPTH:0]   rdy;
  logic [DEPTH-1:0] en;
  logic [DEPTH-1:0] vld_in;

  always_comb begin
    rdy[DEPTH] = out_ready;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign en       = rdy[DEPTH-1:0];
  assign vld_in   = {vld[DEPTH-2:0], in_valid};
  assign in_ready = rdy[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        if (en[i]) vld[i] <= vld_in[i];
      end
    end
  end

  // ---------------- stage 0: keyframe lerp products ----------------
  // Groups: current position, current normal, previous position, previous normal.
  logic [3*CW-1:0]      grp_from [4];
  logic [3*CW-1:0]      grp_to   [4];
  logic signed [CW-1:0] s0_a     [4][3];
  logic signed [PW-1:0] s0_prod  [4][3];

  assign grp_from[0] = cur_pos_from;
  assign grp_from[1] = cur_nrm_from;
  assign grp_from[2] = prev_pos_from;
  assign grp_from[3] = prev_nrm_from;
  assign grp_to[0]   = cur_pos_to;
  assign grp_to[1]   = cur_nrm_to;
  assign grp_to[2]   = prev_pos_to;
  assign grp_to[3]   = prev_nrm_to;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int g = 0; g < 4; g++) begin
        for (int c = 0; c < 3; c++) begin
          s0_a[g][c] <= $signed(grp_from[g][c*CW +: CW]);
          s0_prod[g][c] <= PW'(
            ($signed({grp_to[g][c*CW+CW-1], grp_to[g][c*CW +: CW]})
             - $signed({grp_from[g][c*CW+CW-1], grp_from[g][c*CW +: CW]}))
            * $signed({1'b0, (g < 2) ? tc : tp}));
        end
      end
    end
  end

  // ---------------- stage 1: finish lerps ----------------
  logic signed [CW-1:0] s1_l [4][3];
  logic signed [PW-1:0] s1_sh [4][3];

  always_comb begin
    for (int g = 0; g < 4; g++) begin
      for (int c = 0; c < 3; c++) begin
        s1_sh[g][c] = (s0_prod[g][c] + $signed(HALF)) >>> WF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int g = 0; g < 4; g++) begin
        for (int c = 0; c < 3; c++) begin
          s1_l[g][c] <= s0_a[g][c] + s1_sh[g][c][CW-1:0];
        end
      end
    end
  end

  // ---------------- stage 2: crossfade products ----------------
  // Index k: 0 position, 1 normal. Previous is the lerp start, current the end.
  logic signed [CW-1:0] s2_prev [2][3];
  logic signed [CW-1:0] s2_cur  [2][3];
  logic signed [PW-1:0] s2_prod [2][3];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 2; k++) begin
        for (int c = 0; c < 3; c++) begin
          s2_prev[k][c] <= s1_l[k+2][c];
          s2_cur[k][c]  <= s1_l[k][c];
          s2_prod[k][c] <= PW'(
            ($signed({s1_l[k][c][CW-1], s1_l[k][c]})
             - $signed({s1_l[k+2][c][CW-1], s1_l[k+2][c]}))
            * $signed({1'b0, wb}));
        end
      end
    end
  end

  // ---------------- stage 3: finish crossfade ----------------
  logic signed [CW-1:0] s3_v  [2][3];
  logic signed [PW-1:0] s3_sh [2][3];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int c = 0; c < 3; c++) begin
        s3_sh[k][c] = (s2_prod[k][c] + $signed(HALF)) >>> WF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int k = 0; k < 2; k++) begin
        for (int c = 0; c < 3; c++) begin
          s3_v[k][c] <= blending ? s2_prev[k][c] + s3_sh[k][c][CW-1:0] : s2_cur[k][c];
        end
      end
    end
  end

  // ---------------- stage 4: squares of the normal ----------------
  logic [3*CW-1:0]      s4_pos;
  logic [2*CW-1:0]      s4_sq  [3];
  logic [2:0]           s4_neg;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int c = 0; c < 3; c++) begin
        s4_pos[c*CW +: CW] <= s3_v[0][c];
        s4_sq[c]           <= (2*CW)'(s3_v[1][c] * s3_v[1][c]);
        s4_neg[c]          <= s3_v[1][c][CW-1];
      end
    end
  end

  // ---------------- stage 5: length and search seed ----------------
  // Seed with m = 0: remainder R - s, where R = 4 v^2 2^(2NF), and Y = (2m-1) s = -s.
  logic [SW-1:0]       s4_sum;
  logic [3*CW-1:0]     s5_pos;
  logic                s5_zero;
  logic [SW-1:0]       s5_s;
  logic signed [W-1:0] s5_d [3];
  logic [2:0]          s5_neg;

  assign s4_sum = SW'(s4_sq[0]) + SW'(s4_sq[1]) + SW'(s4_sq[2]);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_pos  <= s4_pos;
      s5_zero <= !normals_present || (s4_sum == '0);
      s5_s    <= s4_sum;
      s5_neg  <= s4_neg;
      for (int c = 0; c < 3; c++) begin
        s5_d[c] <= ($signed(W'(s4_sq[c])) <<< (2 * NF + 2)) - $signed(W'(s4_sum));
      end
    end
  end

  // ---------------- normalization search lanes ----------------
  logic [NF:0]         lane_m   [3];
  logic [2:0]          lane_neg;
  logic signed [W-1:0] y_seed;

  assign y_seed = -$signed(W'(s5_s));

  for (genvar c = 0; c < 3; c++) begin : g_lane
    mvb_root_lane #(.CW(CW)) u_lane (
      .clk     (clk),
      .en      (en[ROOT0 +: NROOT]),
      .d_in    (s5_d[c]),
      .y_in    (y_seed),
      .s_in    (s5_s),
      .neg_in  (s5_neg[c]),
      .m_out   (lane_m[c]),
      .neg_out (lane_neg[c])
    );
  end

  // Carry position and the default-normal flag alongside the lanes.
  logic [3*CW-1:0] rt_pos  [NROOT];
  logic            rt_zero [NROOT];

  always_ff @(posedge clk) begin
    for (int j = 0; j < NROOT; j++) begin
      if (en[ROOT0 + j]) begin
        if (j == 0) begin
          rt_pos[j]  <= s5_pos;
          rt_zero[j] <= s5_zero;
        end else begin
          rt_pos[j]  <= rt_pos[j-1];
          rt_zero[j] <= rt_zero[j-1];
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic [3*CW-1:0] nrm_next;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (rt_zero[NROOT-1]) begin
        nrm_next[c*CW +: CW] = (c == 1) ? (CW'(1) << NF) : '0;
      end else if (lane_neg[c]) begin
        nrm_next[c*CW +: CW] = -CW'(lane_m[c]);
      end else begin
        nrm_next[c*CW +: CW] = CW'(lane_m[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[DEPTH-1]) begin
      position_out <= rt_pos[NROOT-1];
      normal_out   <= nrm_next;
    end
  end

  assign out_valid = vld[DEPTH-1];

endmodule
`default_nettype wire
